// ===== design/srp_pkg.sv =====
// Package for the S19 record character parser: codes, character constants,
// the parser state and result structs, and the hex digit decoder.
// No dependencies; every other design file refers to it by scoped names.
package srp_pkg;

  // Result codes carried on the kind field
  typedef enum logic [1:0] {
    KindWrite   = 2'd0,
    KindStart   = 2'd1,
    KindBadType = 2'd2,
    KindBadHex  = 2'd3
  } kind_e;

  // Record type latched from character 1 of a line
  typedef enum logic [1:0] {
    RecNone = 2'd0,
    RecS1   = 2'd1,
    RecS5   = 2'd2,
    RecS9   = 2'd3
  } rec_e;

  localparam int unsigned PosWidth = 10;
  localparam logic [PosWidth-1:0] PosMax = 10'd1023;

  localparam logic [7:0] CharS    = 8'h53;  // 'S'
  localparam logic [7:0] CharOne  = 8'h31;  // '1'
  localparam logic [7:0] CharFive = 8'h35;  // '5'
  localparam logic [7:0] CharNine = 8'h39;  // '9'
  localparam logic [7:0] CharZero = 8'h30;  // '0'
  localparam logic [7:0] CharUpA  = 8'h41;  // 'A'
  localparam logic [7:0] CharLowA = 8'h61;  // 'a'

  // Line state that carries from one character to the next
  typedef struct packed {
    logic [PosWidth-1:0] pos;
    rec_e                rec;
    logic [15:0]         addr;
    logic [3:0]          high_nib;
    logic [7:0]          held_byte;
    logic                held_valid;
    logic                failed;
  } parse_state_t;

  // One result item plus its valid flag
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  value;
  } result_t;

  // Digit value in bits 3:0; bit 4 set when c is not a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = 5'(c - CharZero);
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 5'(c - CharUpA + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 5'(c - CharLowA + 8'd10);
    end
    return v;
  endfunction

endpackage

// ===== design/srp_ifs.sv =====
// Valid/ready channel interfaces for the S19 record character parser.
// Depends on srp_pkg for the kind code type.
interface srp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source(output valid, ch, line_end, input ready);
  modport sink(input valid, ch, line_end, output ready);
endinterface

interface srp_rec_if;
  logic                valid;
  logic                ready;
  srp_pkg::kind_e      kind;
  logic [15:0]         address;
  logic [7:0]          value;

  modport source(output valid, kind, address, value, input ready);
  modport sink(input valid, kind, address, value, output ready);
endinterface

// ===== design/srp_step.sv =====
// Combinational parse step: given the line state and one character, produce
// the next line state and at most one result. Depends on srp_pkg.
module srp_step (
  input  srp_pkg::parse_state_t st_i,
  input  logic [7:0]            ch_i,
  input  logic                  last_i,
  output srp_pkg::parse_state_t st_o,
  output srp_pkg::result_t      res_o
);

  logic [4:0] nib;
  logic       is_hex;

  assign nib    = srp_pkg::hex_value(ch_i);
  assign is_hex = ~nib[4];

  always_comb begin
    st_o  = st_i;
    res_o = '0;

    if (!st_i.failed) begin
      if (st_i.pos == '0) begin
        if (ch_i != srp_pkg::CharS || last_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = srp_pkg::KindBadType;
          st_o.failed = 1'b1;
        end
      end else if (st_i.pos == srp_pkg::PosWidth'(1)) begin
        case (ch_i)
          srp_pkg::CharOne:  st_o.rec = srp_pkg::RecS1;
          srp_pkg::CharFive: st_o.rec = srp_pkg::RecS5;
          srp_pkg::CharNine: st_o.rec = srp_pkg::RecS9;
          default: begin
            st_o.rec    = srp_pkg::RecNone;
            res_o.valid = 1'b1;
            res_o.kind  = srp_pkg::KindBadType;
            st_o.failed = 1'b1;
          end
        endcase
      end else if (st_i.pos >= srp_pkg::PosWidth'(4) &&
                   (st_i.rec == srp_pkg::RecS1 || st_i.rec == srp_pkg::RecS9)) begin
        if (!is_hex) begin
          res_o.valid = 1'b1;
          res_o.kind  = srp_pkg::KindBadHex;
          st_o.failed = 1'b1;
        end else if (st_i.pos <= srp_pkg::PosWidth'(7)) begin
          // shift in one address digit
          st_o.addr = {st_i.addr[11:0], nib[3:0]};
          if (st_i.pos == srp_pkg::PosWidth'(7) && st_i.rec == srp_pkg::RecS9) begin
            res_o.valid   = 1'b1;
            res_o.kind    = srp_pkg::KindStart;
            res_o.address = {st_i.addr[11:0], nib[3:0]};
          end
        end else if (st_i.rec == srp_pkg::RecS1) begin
          if (!st_i.pos[0]) begin
            st_o.high_nib = nib[3:0];
          end else begin
            // release the previous byte; the newest one may be the checksum
            if (st_i.held_valid) begin
              res_o.valid   = 1'b1;
              res_o.kind    = srp_pkg::KindWrite;
              res_o.address = st_i.addr;
              res_o.value   = st_i.held_byte;
              st_o.addr     = st_i.addr + 16'd1;
            end
            st_o.held_byte  = {st_i.high_nib, nib[3:0]};
            st_o.held_valid = 1'b1;
          end
        end
      end
    end

    if (st_i.pos == srp_pkg::PosMax) begin
      st_o.pos = srp_pkg::PosMax - srp_pkg::PosWidth'(1);
    end else begin
      st_o.pos = st_i.pos + srp_pkg::PosWidth'(1);
    end

    if (last_i) begin
      st_o.pos        = '0;
      st_o.rec        = srp_pkg::RecNone;
      st_o.held_valid = 1'b0;
      st_o.failed     = 1'b0;
    end
  end

endmodule

// ===== design/srecord_s19_char_parser.sv =====
// Top level of the S19 record character parser: input register, line state,
// result register. Depends on srp_pkg, srp_ifs and srp_step.
//
//   Channel  Dir  Fields                     Transaction
//   chr_i    in   ch[7:0], line_end          one record character
//   rec_o    out  kind[1:0], address, value  one write, start, or error report
//
// Each character is held in the input register, then its result (if
// any) lands in the result register when the character advances.
// One character per cycle is sustained while rec_o is ready; the parse step
// between the two registers is combinational.
// Reset clears the line state and both valid flags; parsing starts at char 0.
// A stall on rec_o holds the result register; one more character is still
// taken into the input register before chr_i.ready drops.
module srecord_s19_char_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  srp_char_if.sink   chr_i,
  srp_rec_if.source  rec_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_ch_q;
  logic       in_last_q;

  // line state
  srp_pkg::parse_state_t st_q, st_d;

  // result register
  logic           out_valid_q;
  srp_pkg::kind_e out_kind_q;
  logic [15:0]    out_addr_q;
  logic [7:0]     out_value_q;

  srp_pkg::result_t res;
  logic             advance;

  // Advance the held character when the result register is free or draining
  assign advance     = in_valid_q && (!out_valid_q || rec_o.ready);
  assign chr_i.ready = !in_valid_q || advance;

  srp_step u_step (
    .st_i   (st_q),
    .ch_i   (in_ch_q),
    .last_i (in_last_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // Capture an incoming character; drop the flag once it has been parsed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (chr_i.ready) begin
      in_valid_q <= chr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chr_i.ready && chr_i.valid) begin
      in_ch_q   <= chr_i.ch;
      in_last_q <= chr_i.line_end;
    end
  end

  // Commit the line state only when the character really moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register: load on advance, clear when taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (rec_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_kind_q  <= res.kind;
      out_addr_q  <= res.address;
      out_value_q <= res.value;
    end
  end

  assign rec_o.valid   = out_valid_q;
  assign rec_o.kind    = out_kind_q;
  assign rec_o.address = out_addr_q;
  assign rec_o.value   = out_value_q;

  // Backpressure on the input only when a character is already waiting
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chr_i.ready |-> in_valid_q)
    else $error("chr_i.ready low with empty input register");

  // Only memory writes carry a data byte
  a_value_zero_unless_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_o.valid |-> (rec_o.kind == srp_pkg::KindWrite || rec_o.value == 8'h00))
    else $error("non-write result with nonzero value");

  // A parsed line end restarts the line at character zero
  a_line_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (st_q.pos == '0 && !st_q.failed && !st_q.held_valid))
    else $error("line state not cleared after line end");

  // A held data byte only exists inside an S1 record
  a_held_only_in_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.held_valid |-> st_q.rec == srp_pkg::RecS1)
    else $error("held byte outside an S1 record");

endmodule
